[rtl/fts_pkg.sv]
// ----------------------------------------------------------------------------
// fts_pkg
// Types, codes and corner helpers shared by the fog tile corner shader.
// ----------------------------------------------------------------------------
package fts_pkg;

    // Shade codes, one per tile corner
    typedef logic [1:0] t_shade_code;
    localparam t_shade_code SHADE_CLEAR = 2'd0;
    localparam t_shade_code SHADE_DIM   = 2'd1;
    localparam t_shade_code SHADE_BLACK = 2'd2;

    // Neighbor bit positions in the seen / discovered masks
    localparam int NB_TL = 0;
    localparam int NB_T  = 1;
    localparam int NB_TR = 2;
    localparam int NB_L  = 3;
    localparam int NB_R  = 4;
    localparam int NB_BL = 5;
    localparam int NB_B  = 6;
    localparam int NB_BR = 7;

    // Configuration register indexes and reset values
    typedef logic [0:0] t_cfg_addr;
    localparam t_cfg_addr CFG_MAP_WIDTH  = 1'b0;
    localparam t_cfg_addr CFG_MAP_HEIGHT = 1'b1;

    localparam int CFG_DATA_W = 8;
    localparam logic [7:0] WIDTH_RESET  = 8'd77;
    localparam logic [6:0] HEIGHT_RESET = 7'd43;

    // One input tile
    typedef struct packed {
        logic [6:0] column;
        logic [5:0] row;
        logic       center_seen;
        logic       center_discovered;
        logic [7:0] neighbor_seen;
        logic [7:0] neighbor_discovered;
    } t_tile;

    // One result
    typedef struct packed {
        logic        shade_written;
        t_shade_code shade_top_left;
        t_shade_code shade_top_right;
        t_shade_code shade_bottom_right;
        t_shade_code shade_bottom_left;
    } t_shade;

    // Interior corner: diagonal plus two adjacent neighbors
    function automatic t_shade_code inner_corner(
        input logic       seen,
        input logic [2:0] sm,
        input logic [2:0] dm
    );
        t_shade_code res;
        if (!(&dm)) begin
            res = SHADE_BLACK;
        end else if (seen && (&sm)) begin
            res = SHADE_CLEAR;
        end else begin
            res = SHADE_DIM;
        end
        return res;
    endfunction

    // Border corner: one orthogonal neighbor along the edge
    function automatic t_shade_code edge_corner(
        input logic seen,
        input logic sm,
        input logic dm
    );
        t_shade_code res;
        if (seen && sm) begin
            res = SHADE_CLEAR;
        end else if (dm) begin
            res = SHADE_DIM;
        end else begin
            res = SHADE_BLACK;
        end
        return res;
    endfunction

endpackage

[rtl/fts_tile_if.sv]
// ----------------------------------------------------------------------------
// fts_tile_if
// Valid/ready channel carrying one tile item.
// ----------------------------------------------------------------------------
interface fts_tile_if;
    logic          valid;
    logic          ready;
    fts_pkg::t_tile data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/fts_shade_if.sv]
// ----------------------------------------------------------------------------
// fts_shade_if
// Valid/ready channel carrying one corner shade item.
// ----------------------------------------------------------------------------
interface fts_shade_if;
    logic            valid;
    logic            ready;
    fts_pkg::t_shade data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/fts_cfg_regs.sv]
// ----------------------------------------------------------------------------
// fts_cfg_regs
// Map size registers, clamped to the supported maximum map size.
// ----------------------------------------------------------------------------
module fts_cfg_regs #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  fts_pkg::t_cfg_addr                i_cfg_addr,
    input  logic [fts_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    output logic [7:0]                        o_width,
    output logic [6:0]                        o_height
);

    // Limits saturate at what the register can hold
    localparam logic [7:0] WIDTH_LIM  = (MAX_WIDTH > 255) ? 8'd255 : 8'(MAX_WIDTH);
    localparam logic [6:0] HEIGHT_LIM = (MAX_HEIGHT > 127) ? 7'd127 : 7'(MAX_HEIGHT);

    logic [7:0] r_width;
    logic [6:0] r_height;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= fts_pkg::WIDTH_RESET;
            r_height <= fts_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                fts_pkg::CFG_MAP_WIDTH:  r_width  <= i_cfg_wdata[7:0];
                fts_pkg::CFG_MAP_HEIGHT: r_height <= i_cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    // Clamp to the maximum map size
    assign o_width  = (r_width  > WIDTH_LIM)  ? WIDTH_LIM  : r_width;
    assign o_height = (r_height > HEIGHT_LIM) ? HEIGHT_LIM : r_height;

endmodule

[rtl/fts_shade_logic.sv]
// ----------------------------------------------------------------------------
// fts_shade_logic
// Corner shade decision for one tile: interior blend or border rules.
// ----------------------------------------------------------------------------
module fts_shade_logic (
    input  fts_pkg::t_tile  i_tile,
    input  logic [7:0]      i_width,
    input  logic [6:0]      i_height,
    output fts_pkg::t_shade o_shade
);

    logic [8:0] col_p1;
    logic [7:0] row_p1;
    logic       col_first, col_last, col_mid;
    logic       row_first, row_last, row_mid;
    logic       seen, written;
    logic [7:0] sm, dm;
    fts_pkg::t_shade_code open_code;
    fts_pkg::t_shade_code s_tl, s_tr, s_br, s_bl;

    assign seen    = i_tile.center_seen;
    assign written = i_tile.center_seen | i_tile.center_discovered;
    assign sm      = i_tile.neighbor_seen;
    assign dm      = i_tile.neighbor_discovered;

    // Position classes; col == last means col + 1 == width, no negatives
    assign col_p1    = {2'b00, i_tile.column} + 9'd1;
    assign row_p1    = {2'b00, i_tile.row} + 8'd1;
    assign col_first = (i_tile.column == '0);
    assign row_first = (i_tile.row == '0);
    assign col_last  = (col_p1 == {1'b0, i_width});
    assign row_last  = (row_p1 == {1'b0, i_height});
    assign col_mid   = !col_first && (col_p1 < {1'b0, i_width});
    assign row_mid   = !row_first && (row_p1 < {1'b0, i_height});

    assign open_code = seen ? fts_pkg::SHADE_CLEAR : fts_pkg::SHADE_DIM;

    // Corner selection; border cases in fixed priority order
    always_comb begin
        s_tl = fts_pkg::SHADE_BLACK;
        s_tr = fts_pkg::SHADE_BLACK;
        s_br = fts_pkg::SHADE_BLACK;
        s_bl = fts_pkg::SHADE_BLACK;
        if (col_mid && row_mid) begin
            s_tl = fts_pkg::inner_corner(seen,
                {sm[fts_pkg::NB_TL], sm[fts_pkg::NB_L], sm[fts_pkg::NB_T]},
                {dm[fts_pkg::NB_TL], dm[fts_pkg::NB_L], dm[fts_pkg::NB_T]});
            s_tr = fts_pkg::inner_corner(seen,
                {sm[fts_pkg::NB_TR], sm[fts_pkg::NB_R], sm[fts_pkg::NB_T]},
                {dm[fts_pkg::NB_TR], dm[fts_pkg::NB_R], dm[fts_pkg::NB_T]});
            s_br = fts_pkg::inner_corner(seen,
                {sm[fts_pkg::NB_BR], sm[fts_pkg::NB_R], sm[fts_pkg::NB_B]},
                {dm[fts_pkg::NB_BR], dm[fts_pkg::NB_R], dm[fts_pkg::NB_B]});
            s_bl = fts_pkg::inner_corner(seen,
                {sm[fts_pkg::NB_BL], sm[fts_pkg::NB_L], sm[fts_pkg::NB_B]},
                {dm[fts_pkg::NB_BL], dm[fts_pkg::NB_L], dm[fts_pkg::NB_B]});
        end else if (col_first && row_first) begin
            s_br = open_code;
        end else if (col_last && row_first) begin
            s_bl = open_code;
        end else if (col_first && row_last) begin
            s_tr = open_code;
        end else if (col_last && row_last) begin
            s_tl = open_code;
        end else if (col_first && row_mid) begin
            s_tr = fts_pkg::edge_corner(seen, sm[fts_pkg::NB_T], dm[fts_pkg::NB_T]);
            s_br = fts_pkg::edge_corner(seen, sm[fts_pkg::NB_B], dm[fts_pkg::NB_B]);
        end else if (col_last && row_mid) begin
            s_tl = fts_pkg::edge_corner(seen, sm[fts_pkg::NB_T], dm[fts_pkg::NB_T]);
            s_bl = fts_pkg::edge_corner(seen, sm[fts_pkg::NB_B], dm[fts_pkg::NB_B]);
        end else if (row_first && col_mid) begin
            s_br = fts_pkg::edge_corner(seen, sm[fts_pkg::NB_R], dm[fts_pkg::NB_R]);
            s_bl = fts_pkg::edge_corner(seen, sm[fts_pkg::NB_L], dm[fts_pkg::NB_L]);
        end else if (row_last && col_mid) begin
            s_tr = fts_pkg::edge_corner(seen, sm[fts_pkg::NB_R], dm[fts_pkg::NB_R]);
            s_tl = fts_pkg::edge_corner(seen, sm[fts_pkg::NB_L], dm[fts_pkg::NB_L]);
        end
    end

    // Unshaded tiles report all zero
    always_comb begin
        o_shade.shade_written      = written;
        o_shade.shade_top_left     = written ? s_tl : fts_pkg::SHADE_CLEAR;
        o_shade.shade_top_right    = written ? s_tr : fts_pkg::SHADE_CLEAR;
        o_shade.shade_bottom_right = written ? s_br : fts_pkg::SHADE_CLEAR;
        o_shade.shade_bottom_left  = written ? s_bl : fts_pkg::SHADE_CLEAR;
    end

endmodule

[rtl/fog_tile_corner_shader.sv]
// ----------------------------------------------------------------------------
// fog_tile_corner_shader
// Corner shades for a stream of visibility map tiles.
// ----------------------------------------------------------------------------
// Usage:
//   i_tile carries one tile item (position, own flags, neighbor masks) with
//   valid/ready; o_shade returns one shade item per tile, in order.
//   The map size is set through the write port (index 0 width, index 1
//   height) while no item is in flight; values above the maximum map size
//   act as the maximum.
//   A tile passes from the input register through the shade logic into the
//   result register, which presents it on o_shade. Throughput: one item per
//   cycle when o_shade is ready, set by the single input and result register.
//   When the receiver stalls, the result register holds its item and the
//   input register still takes one more tile; ready drops only when both
//   are full. Reset empties both registers and loads the map size with
//   77 columns by 43 rows.
// ----------------------------------------------------------------------------
module fog_tile_corner_shader #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  fts_pkg::t_cfg_addr             i_cfg_addr,
    input  logic [fts_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    fts_tile_if.sink                       i_tile,
    fts_shade_if.source                    o_shade
);

    logic [7:0]      width;
    logic [6:0]      height;
    logic            r_s1_vld;
    fts_pkg::t_tile  r_s1_tile;
    logic            r_out_vld;
    fts_pkg::t_shade r_out_shade;
    fts_pkg::t_shade n_out_shade;
    logic            in_accept;
    logic            out_load;

    fts_cfg_regs #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_width     (width),
        .o_height    (height)
    );

    fts_shade_logic u_logic (
        .i_tile   (r_s1_tile),
        .i_width  (width),
        .i_height (height),
        .o_shade  (n_out_shade)
    );

    // Handshake: result register frees when empty or taken
    assign out_load       = r_s1_vld && (!r_out_vld || o_shade.ready);
    assign i_tile.ready   = !r_s1_vld || out_load;
    assign in_accept      = i_tile.valid && i_tile.ready;
    assign o_shade.valid  = r_out_vld;
    assign o_shade.data   = r_out_shade;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_accept) begin
            r_s1_vld <= 1'b1;
        end else if (out_load) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_tile <= i_tile.data;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (o_shade.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_shade <= n_out_shade;
        end
    end

`ifndef SYNTHESIS
    // An accepted tile is held in the input register next cycle
    a_accept_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_s1_vld)
        else $error("accepted tile lost from input register");

    // A waiting tile with a blocked result register stays put
    a_s1_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !out_load) |=> (r_s1_vld && $stable(r_s1_tile)))
        else $error("stalled tile dropped or changed");

    // Unshaded result carries all zero corners
    a_zero_unwritten: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out_shade.shade_written) |->
        (r_out_shade.shade_top_left == fts_pkg::SHADE_CLEAR &&
         r_out_shade.shade_top_right == fts_pkg::SHADE_CLEAR &&
         r_out_shade.shade_bottom_right == fts_pkg::SHADE_CLEAR &&
         r_out_shade.shade_bottom_left == fts_pkg::SHADE_CLEAR))
        else $error("unshaded tile with nonzero corners");

    // Loaded result reflects the tile flags
    a_written_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_out_shade.shade_written ==
        ($past(r_s1_tile.center_seen) || $past(r_s1_tile.center_discovered))))
        else $error("shade_written does not match tile flags");
`endif

endmodule
